[src/rrc_pkg.sv]
// ----------------------------------------------------------------------------
// rrc_pkg
// Shared types and constants of the rotated rectangle corner generator.
// ----------------------------------------------------------------------------
package rrc_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int ANGLE_BITS_DEF = 16;

  // Sine and cosine are signed Q1.15.
  localparam int TRIG_BITS = 16;

  typedef enum logic [1:0] {
    CORNER_BL = 2'd0,
    CORNER_TL = 2'd1,
    CORNER_TR = 2'd2,
    CORNER_BR = 2'd3
  } corner_t;

endpackage

[src/rrc_trig.sv]
// ----------------------------------------------------------------------------
// rrc_trig
// Sine and cosine lookup: a quarter-wave ROM read at two phases, then the
// quadrant signs are applied. Two register stages; the sprite fields travel
// alongside.
// ----------------------------------------------------------------------------
module rrc_trig #(
  parameter int COORD_BITS = rrc_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = rrc_pkg::ANGLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_BITS-1:0]        in_x,
  input  logic signed [COORD_BITS-1:0]        in_y,
  input  logic signed [COORD_BITS-1:0]        in_z,
  input  logic        [COORD_BITS-2:0]        in_w,
  input  logic        [COORD_BITS-2:0]        in_h,
  input  logic        [ANGLE_BITS-1:0]        in_angle,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [COORD_BITS-1:0]        out_x,
  output logic signed [COORD_BITS-1:0]        out_y,
  output logic signed [COORD_BITS-1:0]        out_z,
  output logic        [COORD_BITS-2:0]        out_w,
  output logic        [COORD_BITS-2:0]        out_h,
  output logic signed [rrc_pkg::TRIG_BITS-1:0] out_sin,
  output logic signed [rrc_pkg::TRIG_BITS-1:0] out_cos,
  output logic                                out_zero
);
  import rrc_pkg::*;

  localparam int    AW   = ANGLE_BITS - 1;
  localparam int    Q    = 1 << (ANGLE_BITS - 2);
  localparam int    MAGW = TRIG_BITS - 1;
  localparam longint C_A1 = 64'sd1686629713;
  localparam longint C_A3 = -64'sd693598668;
  localparam longint C_A5 = 64'sd85569305;
  localparam longint C_A7 = -64'sd5026995;
  localparam longint C_A9 = 64'sd172272;

  function automatic logic [MAGW-1:0] quarter_sine(longint p);
    longint t;
    longint t2;
    longint r;
    longint q15;
    t  = p <<< (30 - (ANGLE_BITS - 2));
    t2 = (t * t) >>> 30;
    r  = C_A9;
    r  = C_A7 + ((r * t2) >>> 30);
    r  = C_A5 + ((r * t2) >>> 30);
    r  = C_A3 + ((r * t2) >>> 30);
    r  = C_A1 + ((r * t2) >>> 30);
    r  = (r * t) >>> 30;
    q15 = (r + 64'sd16384) >>> 15;
    if (q15 > 64'sd32767) begin
      q15 = 64'sd32767;
    end
    if (q15 < 64'sd0) begin
      q15 = 64'sd0;
    end
    return q15[MAGW-1:0];
  endfunction

  logic [MAGW-1:0]        sin_rom [Q+1];

  logic                   ready2;
  logic [AW-1:0]          addr_a;
  logic [AW-1:0]          addr_b;

  logic                   v1_r;
  logic [1:0]             quad1_r;
  logic [MAGW-1:0]        rom_a_r;
  logic [MAGW-1:0]        rom_b_r;
  logic signed [COORD_BITS-1:0] x1_r, y1_r, z1_r;
  logic [COORD_BITS-2:0]  w1_r, h1_r;
  logic                   zero1_r;

  logic                   v2_r;
  logic signed [TRIG_BITS-1:0] pos_a, pos_b, sin_nxt, cos_nxt;
  logic signed [TRIG_BITS-1:0] sin2_r, cos2_r;
  logic signed [COORD_BITS-1:0] x2_r, y2_r, z2_r;
  logic [COORD_BITS-2:0]  w2_r, h2_r;
  logic                   zero2_r;

  // The ROM contents are fixed and loaded once at start-up.
  initial begin
    for (int i = 0; i <= Q; i++) begin
      sin_rom[i] = quarter_sine(longint'(i));
    end
  end

  assign ready2   = !v2_r || out_ready;
  assign in_ready = !v1_r || ready2;

  assign addr_a = {1'b0, in_angle[ANGLE_BITS-3:0]};
  assign addr_b = {1'b1, {(AW-1){1'b0}}} - addr_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_ready) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      rom_a_r <= sin_rom[addr_a];
      rom_b_r <= sin_rom[addr_b];
      quad1_r <= in_angle[ANGLE_BITS-1:ANGLE_BITS-2];
      zero1_r <= (in_angle == '0);
      x1_r    <= in_x;
      y1_r    <= in_y;
      z1_r    <= in_z;
      w1_r    <= in_w;
      h1_r    <= in_h;
    end
  end

  assign pos_a = $signed({1'b0, rom_a_r});
  assign pos_b = $signed({1'b0, rom_b_r});

  always_comb begin
    case (quad1_r)
      2'd0: begin
        sin_nxt = pos_a;
        cos_nxt = pos_b;
      end
      2'd1: begin
        sin_nxt = pos_b;
        cos_nxt = -pos_a;
      end
      2'd2: begin
        sin_nxt = -pos_a;
        cos_nxt = -pos_b;
      end
      default: begin
        sin_nxt = -pos_b;
        cos_nxt = pos_a;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (ready2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      sin2_r  <= sin_nxt;
      cos2_r  <= cos_nxt;
      zero2_r <= zero1_r;
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      z2_r    <= z1_r;
      w2_r    <= w1_r;
      h2_r    <= h1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_x     = x2_r;
  assign out_y     = y2_r;
  assign out_z     = z2_r;
  assign out_w     = w2_r;
  assign out_h     = h2_r;
  assign out_sin   = sin2_r;
  assign out_cos   = cos2_r;
  assign out_zero  = zero2_r;

endmodule

[src/rrc_seq.sv]
// ----------------------------------------------------------------------------
// rrc_seq
// Corner sequencer: holds one sprite and issues its four corners in order,
// one per cycle while not stalled, taking the next sprite as the last leaves.
// ----------------------------------------------------------------------------
module rrc_seq #(
  parameter int COORD_BITS = rrc_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [COORD_BITS-1:0]         in_x,
  input  logic signed [COORD_BITS-1:0]         in_y,
  input  logic signed [COORD_BITS-1:0]         in_z,
  input  logic        [COORD_BITS-2:0]         in_w,
  input  logic        [COORD_BITS-2:0]         in_h,
  input  logic signed [rrc_pkg::TRIG_BITS-1:0] in_sin,
  input  logic signed [rrc_pkg::TRIG_BITS-1:0] in_cos,
  input  logic                                 in_zero,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [COORD_BITS-1:0]         out_x,
  output logic signed [COORD_BITS-1:0]         out_y,
  output logic signed [COORD_BITS-1:0]         out_z,
  output logic        [COORD_BITS-2:0]         out_w,
  output logic        [COORD_BITS-2:0]         out_h,
  output logic signed [rrc_pkg::TRIG_BITS-1:0] out_sin,
  output logic signed [rrc_pkg::TRIG_BITS-1:0] out_cos,
  output logic                                 out_zero,
  output rrc_pkg::corner_t                     out_corner
);
  import rrc_pkg::*;

  logic                         v_r;
  corner_t                      k_r;
  corner_t                      k_nxt;
  logic signed [COORD_BITS-1:0] x_r, y_r, z_r;
  logic [COORD_BITS-2:0]        w_r, h_r;
  logic signed [TRIG_BITS-1:0]  sin_r, cos_r;
  logic                         zero_r;

  assign in_ready = !v_r || (k_r == CORNER_BR && out_ready);

  always_comb begin
    case (k_r)
      CORNER_BL: k_nxt = CORNER_TL;
      CORNER_TL: k_nxt = CORNER_TR;
      CORNER_TR: k_nxt = CORNER_BR;
      default:   k_nxt = CORNER_BL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
      k_r <= CORNER_BL;
    end else if (in_ready) begin
      v_r <= in_valid;
      k_r <= CORNER_BL;
    end else if (out_ready) begin
      k_r <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      x_r    <= in_x;
      y_r    <= in_y;
      z_r    <= in_z;
      w_r    <= in_w;
      h_r    <= in_h;
      sin_r  <= in_sin;
      cos_r  <= in_cos;
      zero_r <= in_zero;
    end
  end

  assign out_valid  = v_r;
  assign out_x      = x_r;
  assign out_y      = y_r;
  assign out_z      = z_r;
  assign out_w      = w_r;
  assign out_h      = h_r;
  assign out_sin    = sin_r;
  assign out_cos    = cos_r;
  assign out_zero   = zero_r;
  assign out_corner = k_r;

endmodule

[src/rrc_rotate.sv]
// ----------------------------------------------------------------------------
// rrc_rotate
// Corner rotation pipeline: products, sums about the doubled centre, then
// rounding and saturation. The last stage is the result register.
// ----------------------------------------------------------------------------
module rrc_rotate #(
  parameter int COORD_BITS = rrc_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [COORD_BITS-1:0]         in_x,
  input  logic signed [COORD_BITS-1:0]         in_y,
  input  logic signed [COORD_BITS-1:0]         in_z,
  input  logic        [COORD_BITS-2:0]         in_w,
  input  logic        [COORD_BITS-2:0]         in_h,
  input  logic signed [rrc_pkg::TRIG_BITS-1:0] in_sin,
  input  logic signed [rrc_pkg::TRIG_BITS-1:0] in_cos,
  input  logic                                 in_zero,
  input  rrc_pkg::corner_t                     in_corner,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [COORD_BITS-1:0]         out_x,
  output logic signed [COORD_BITS-1:0]         out_y,
  output logic signed [COORD_BITS-1:0]         out_z,
  output rrc_pkg::corner_t                     out_corner,
  output logic                                 out_last
);
  import rrc_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int PW = CB + TRIG_BITS;
  localparam int C2W = CB + 2;
  localparam int RW = CB + 18;
  localparam int ZW = CB + 1;

  logic rdy1, rdy2, rdy3;
  logic v1_r, v2_r, v3_r;

  // First stage: offsets and products.
  logic                  sx_pos, sy_pos;
  logic signed [CB-1:0]  dx2, dy2;
  logic signed [PW-1:0]  pxc_r, pys_r, pxs_r, pyc_r;
  logic signed [C2W-1:0] cx2_r, cy2_r;
  logic signed [ZW-1:0]  zx_r, zy_r;
  logic signed [CB-1:0]  z1_r;
  logic                  zero1_r;
  corner_t               k1_r;

  // Second stage: rounded sums.
  logic signed [RW-1:0]  rx_nxt, ry_nxt, rx_r, ry_r;
  logic signed [CB-1:0]  zsx_nxt, zsy_nxt, zsx_r, zsy_r;
  logic signed [CB-1:0]  z2_r;
  logic                  zero2_r;
  corner_t               k2_r;

  // Third stage: shift and saturate.
  logic signed [C2W-1:0] qx, qy;
  logic signed [CB-1:0]  sqx, sqy;
  logic signed [CB-1:0]  x3_r, y3_r, z3_r;
  corner_t               k3_r;

  localparam logic signed [CB-1:0] SAT_HI = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] SAT_LO = {1'b1, {(CB-1){1'b0}}};

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  assign sx_pos = (in_corner == CORNER_TR) || (in_corner == CORNER_BR);
  assign sy_pos = (in_corner == CORNER_TL) || (in_corner == CORNER_TR);
  assign dx2    = sx_pos ? $signed({1'b0, in_w}) : -$signed({1'b0, in_w});
  assign dy2    = sy_pos ? $signed({1'b0, in_h}) : -$signed({1'b0, in_h});

  always_ff @(posedge clk) begin
    if (rdy1) begin
      pxc_r   <= PW'(dx2) * PW'(in_cos);
      pys_r   <= PW'(dy2) * PW'(in_sin);
      pxs_r   <= PW'(dx2) * PW'(in_sin);
      pyc_r   <= PW'(dy2) * PW'(in_cos);
      cx2_r   <= C2W'($signed({in_x, 1'b0})) + C2W'($signed({2'b00, in_w}));
      cy2_r   <= C2W'($signed({in_y, 1'b0})) + C2W'($signed({2'b00, in_h}));
      zx_r    <= $signed({in_x[CB-1], in_x})
                 + $signed({2'b00, (sx_pos ? in_w : {(CB-1){1'b0}})});
      zy_r    <= $signed({in_y[CB-1], in_y})
                 + $signed({2'b00, (sy_pos ? in_h : {(CB-1){1'b0}})});
      z1_r    <= in_z;
      zero1_r <= in_zero;
      k1_r    <= in_corner;
    end
  end

  always_comb begin
    rx_nxt = (RW'(cx2_r) <<< 15) + RW'(pxc_r) - RW'(pys_r) + RW'(32768);
    ry_nxt = (RW'(cy2_r) <<< 15) + RW'(pxs_r) + RW'(pyc_r) + RW'(32768);
    if (zx_r[ZW-1] != zx_r[ZW-2]) begin
      zsx_nxt = zx_r[ZW-1] ? SAT_LO : SAT_HI;
    end else begin
      zsx_nxt = zx_r[CB-1:0];
    end
    if (zy_r[ZW-1] != zy_r[ZW-2]) begin
      zsy_nxt = zy_r[ZW-1] ? SAT_LO : SAT_HI;
    end else begin
      zsy_nxt = zy_r[CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      rx_r    <= rx_nxt;
      ry_r    <= ry_nxt;
      zsx_r   <= zsx_nxt;
      zsy_r   <= zsy_nxt;
      z2_r    <= z1_r;
      zero2_r <= zero1_r;
      k2_r    <= k1_r;
    end
  end

  assign qx = rx_r[RW-1:16];
  assign qy = ry_r[RW-1:16];

  always_comb begin
    if (qx[C2W-1:CB-1] != {3{qx[C2W-1]}}) begin
      sqx = qx[C2W-1] ? SAT_LO : SAT_HI;
    end else begin
      sqx = qx[CB-1:0];
    end
    if (qy[C2W-1:CB-1] != {3{qy[C2W-1]}}) begin
      sqy = qy[C2W-1] ? SAT_LO : SAT_HI;
    end else begin
      sqy = qy[CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      x3_r <= zero2_r ? zsx_r : sqx;
      y3_r <= zero2_r ? zsy_r : sqy;
      z3_r <= zero2_r ? z2_r : '0;
      k3_r <= k2_r;
    end
  end

  assign out_valid  = v3_r;
  assign out_x      = x3_r;
  assign out_y      = y3_r;
  assign out_z      = z3_r;
  assign out_corner = k3_r;
  assign out_last   = (k3_r == CORNER_BR);

endmodule

[src/rotated_rect_corners.sv]
// ----------------------------------------------------------------------------
// rotated_rect_corners
// Emits the four corners of a sprite rectangle rotated about its centre.
// ----------------------------------------------------------------------------
// Each accepted request gives rise to four corner results, bottom-left,
// top-left, top-right and bottom-right, on consecutive cycles when the output
// is not stalled; the single result channel and the corner sequencer that
// feeds it set that pace, and the next sprite is taken as the last corner
// leaves the sequencer. A request passes the sine and cosine lookup in a
// quarter-wave ROM, the sequencer register, and the multiply, sum and
// round-and-saturate stages. A zero angle gives the exact corners and passes
// z through; any other angle gives z of zero.
module rotated_rect_corners #(
  parameter int COORD_BITS = rrc_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = rrc_pkg::ANGLE_BITS_DEF,
  localparam int IN_RAW   = 5 * COORD_BITS - 2 + ANGLE_BITS,
  localparam int IN_BYTES = (IN_RAW + 7) / 8,
  localparam int OUT_RAW  = 3 * COORD_BITS,
  localparam int OUT_BYTES = (OUT_RAW + 7) / 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // pos_x, pos_y, pos_z, width, height, angle
  input  logic [8*IN_BYTES-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // corner_x, corner_y, corner_z
  output logic [8*OUT_BYTES-1:0] out_tdata,
  // corner_index
  output logic [1:0]             out_tuser,
  output logic                   out_tlast
);
  import rrc_pkg::*;

  localparam int CB = COORD_BITS;

  logic signed [CB-1:0]        pos_x, pos_y, pos_z;
  logic [CB-2:0]               width, height;
  logic [ANGLE_BITS-1:0]       angle;

  logic                        t_valid, t_ready;
  logic signed [CB-1:0]        t_x, t_y, t_z;
  logic [CB-2:0]               t_w, t_h;
  logic signed [TRIG_BITS-1:0] t_sin, t_cos;
  logic                        t_zero;

  logic                        s_valid, s_ready;
  logic signed [CB-1:0]        s_x, s_y, s_z;
  logic [CB-2:0]               s_w, s_h;
  logic signed [TRIG_BITS-1:0] s_sin, s_cos;
  logic                        s_zero;
  corner_t                     s_corner;

  logic signed [CB-1:0]        corner_x, corner_y, corner_z;
  corner_t                     corner_index;

  assign pos_x  = in_tdata[CB-1:0];
  assign pos_y  = in_tdata[2*CB-1:CB];
  assign pos_z  = in_tdata[3*CB-1:2*CB];
  assign width  = in_tdata[4*CB-2:3*CB];
  assign height = in_tdata[5*CB-3:4*CB-1];
  assign angle  = in_tdata[IN_RAW-1:5*CB-2];

  rrc_trig #(
    .COORD_BITS (COORD_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_trig (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_x      (pos_x),
    .in_y      (pos_y),
    .in_z      (pos_z),
    .in_w      (width),
    .in_h      (height),
    .in_angle  (angle),
    .out_valid (t_valid),
    .out_ready (t_ready),
    .out_x     (t_x),
    .out_y     (t_y),
    .out_z     (t_z),
    .out_w     (t_w),
    .out_h     (t_h),
    .out_sin   (t_sin),
    .out_cos   (t_cos),
    .out_zero  (t_zero)
  );

  rrc_seq #(
    .COORD_BITS (COORD_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (t_valid),
    .in_ready   (t_ready),
    .in_x       (t_x),
    .in_y       (t_y),
    .in_z       (t_z),
    .in_w       (t_w),
    .in_h       (t_h),
    .in_sin     (t_sin),
    .in_cos     (t_cos),
    .in_zero    (t_zero),
    .out_valid  (s_valid),
    .out_ready  (s_ready),
    .out_x      (s_x),
    .out_y      (s_y),
    .out_z      (s_z),
    .out_w      (s_w),
    .out_h      (s_h),
    .out_sin    (s_sin),
    .out_cos    (s_cos),
    .out_zero   (s_zero),
    .out_corner (s_corner)
  );

  rrc_rotate #(
    .COORD_BITS (COORD_BITS)
  ) u_rotate (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s_valid),
    .in_ready   (s_ready),
    .in_x       (s_x),
    .in_y       (s_y),
    .in_z       (s_z),
    .in_w       (s_w),
    .in_h       (s_h),
    .in_sin     (s_sin),
    .in_cos     (s_cos),
    .in_zero    (s_zero),
    .in_corner  (s_corner),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_x      (corner_x),
    .out_y      (corner_y),
    .out_z      (corner_z),
    .out_corner (corner_index),
    .out_last   (out_tlast)
  );

  assign out_tdata = (8*OUT_BYTES)'({corner_z, corner_y, corner_x});
  assign out_tuser = corner_index;

endmodule
